@@ src/dtsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_pkg: shared types and constants
// Result record, configuration record, token codes and character constants
// for the dictionary token stream decoder.
// ----------------------------------------------------------------------------
package dtsd_pkg;

    localparam int DEF_SEC_TABLE_COUNT = 4;

    // Result kinds
    localparam logic [2:0] KIND_PRIMARY   = 3'd0;
    localparam logic [2:0] KIND_SECONDARY = 3'd1;
    localparam logic [2:0] KIND_CHAR      = 3'd2;
    localparam logic [2:0] KIND_EMPTY     = 3'd3;
    localparam logic [2:0] KIND_TRUNC     = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_SEC_BASE   = 3'd0;
    localparam logic [2:0] CFG_RAW8       = 3'd1;
    localparam logic [2:0] CFG_RAW20      = 3'd2;
    localparam logic [2:0] CFG_RAW32      = 3'd3;
    localparam logic [2:0] CFG_DIGITS     = 3'd4;
    localparam logic [2:0] CFG_HEX        = 3'd5;

    // Configuration reset values
    localparam logic [7:0] RST_SEC_BASE   = 8'd236;
    localparam logic [7:0] RST_RAW8       = 8'd252;
    localparam logic [7:0] RST_RAW20      = 8'd253;
    localparam logic [7:0] RST_RAW32      = 8'd254;
    localparam logic [7:0] RST_DIGITS     = 8'd255;
    localparam logic [7:0] RST_HEX        = 8'd251;

    // Characters
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_DASH        = 8'h2D;
    localparam logic [7:0] CH_DOT         = 8'h2E;
    localparam logic [7:0] CH_QUEST       = 8'h3F;
    localparam logic [7:0] CH_A           = 8'h41;
    localparam logic [3:0] NIB_STOP       = 4'hF;
    localparam logic [3:0] NIB_DASH       = 4'hA;
    localparam logic [3:0] NIB_DOT        = 4'hB;
    localparam logic [3:0] NIB_TEN        = 4'hA;

    localparam int RES_SLOTS = 3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEC,
        PH_LEN,
        PH_PAY
    } t_phase;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_RAW8,
        TK_RAW20,
        TK_RAW32,
        TK_DIG,
        TK_HEX
    } t_tok;

    typedef struct packed {
        logic       token_done;
        logic [1:0] table_res;
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [7:0] sec_base;
        logic [7:0] raw8;
        logic [7:0] raw20;
        logic [7:0] raw32;
        logic [7:0] digits;
        logic [7:0] hex;
    } t_cfg;

endpackage
`default_nettype wire

@@ src/dtsd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_cfg: marker code registers
// Holds the six token marker codes, written one at a time by index.
// ----------------------------------------------------------------------------
module dtsd_cfg
    import dtsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire logic [2:0] i_index,
    input  wire logic [7:0] i_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sec_base <= RST_SEC_BASE;
            r_cfg.raw8     <= RST_RAW8;
            r_cfg.raw20    <= RST_RAW20;
            r_cfg.raw32    <= RST_RAW32;
            r_cfg.digits   <= RST_DIGITS;
            r_cfg.hex      <= RST_HEX;
        end else if (i_wr) begin
            case (i_index)
                CFG_SEC_BASE: r_cfg.sec_base <= i_data;
                CFG_RAW8:     r_cfg.raw8     <= i_data;
                CFG_RAW20:    r_cfg.raw20    <= i_data;
                CFG_RAW32:    r_cfg.raw32    <= i_data;
                CFG_DIGITS:   r_cfg.digits   <= i_data;
                CFG_HEX:      r_cfg.hex      <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ src/dtsd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_core: token parser
// Holds the parse state and turns one stream byte into up to three results.
// ----------------------------------------------------------------------------
module dtsd_core
    import dtsd_pkg::*;
#(
    parameter int SECONDARY_TABLE_COUNT = DEF_SEC_TABLE_COUNT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    input  wire t_cfg       i_cfg,
    output t_result         o_res [RES_SLOTS],
    output logic [1:0]      o_count
);

    t_phase      r_phase, n_phase;
    t_tok        r_tok,   n_tok;
    logic [1:0]  r_lbl,   n_lbl;
    logic [31:0] r_pl,    n_pl;
    logic [1:0]  r_sec,   n_sec;
    logic        r_stop,  n_stop;

    t_result     res_a, res_b, res_t;
    logic        v_a, v_b, v_t;
    logic        go_idle;

    logic [7:0]  sec_diff;
    logic        is_sec;
    logic [7:0]  len_byte;
    logic [31:0] pl_shift;
    logic [31:0] pl_m1, pl_m2;
    logic        packed_tok, hex_tok;
    logic [8:0]  nib0, nib1;
    logic        stop_after0;
    logic        two_nibs, pay_done;

    // Character for one nibble; bit 8 is set when a character is produced.
    function automatic logic [8:0] nib_char(input logic hex, input logic stop,
                                            input logic [3:0] nib);
        logic [8:0] r;
        r = '0;
        if (hex) begin
            if (nib < NIB_TEN) r = {1'b1, CH_ZERO + {4'd0, nib}};
            else               r = {1'b1, CH_A + {4'd0, nib - NIB_TEN}};
        end else if (!stop) begin
            if (nib < NIB_TEN)         r = {1'b1, CH_ZERO + {4'd0, nib}};
            else if (nib == NIB_DASH)  r = {1'b1, CH_DASH};
            else if (nib == NIB_DOT)   r = {1'b1, CH_DOT};
            else if (nib != NIB_STOP)  r = {1'b1, CH_QUEST};
        end
        return r;
    endfunction

    assign sec_diff   = i_byte - i_cfg.sec_base;
    assign is_sec     = (i_byte >= i_cfg.sec_base)
                        && ({1'b0, sec_diff} < 9'(SECONDARY_TABLE_COUNT));
    assign len_byte   = (r_tok == TK_RAW20 && r_lbl == 2'd2) ? {4'd0, i_byte[3:0]} : i_byte;
    assign pl_shift   = {r_pl[23:0], len_byte};
    assign pl_m1      = r_pl - 32'd1;
    assign pl_m2      = r_pl - 32'd2;
    assign hex_tok    = (r_tok == TK_HEX);
    assign packed_tok = hex_tok || (r_tok == TK_DIG);
    assign two_nibs   = (pl_m1 != 32'd0);
    assign nib0       = nib_char(hex_tok, r_stop, i_byte[7:4]);
    assign stop_after0 = r_stop || (!hex_tok && i_byte[7:4] == NIB_STOP);
    assign nib1       = two_nibs ? nib_char(hex_tok, stop_after0, i_byte[3:0]) : 9'd0;
    assign pay_done   = !two_nibs || (pl_m2 == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tok   <= TK_NONE;
            r_lbl   <= '0;
            r_pl    <= '0;
            r_sec   <= '0;
            r_stop  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tok   <= n_tok;
            r_lbl   <= n_lbl;
            r_pl    <= n_pl;
            r_sec   <= n_sec;
            r_stop  <= n_stop;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tok   = r_tok;
        n_lbl   = r_lbl;
        n_pl    = r_pl;
        n_sec   = r_sec;
        n_stop  = r_stop;
        res_a   = '0;
        res_b   = '0;
        res_t   = '0;
        v_a     = 1'b0;
        v_b     = 1'b0;
        go_idle = 1'b0;

        case (r_phase)
            PH_SEC: begin
                res_a.kind       = KIND_SECONDARY;
                res_a.table_res  = r_sec;
                res_a.value      = i_byte;
                res_a.token_done = 1'b1;
                v_a     = 1'b1;
                go_idle = 1'b1;
            end
            PH_LEN: begin
                n_pl = pl_shift;
                if (r_lbl != 2'd0) begin
                    n_lbl = r_lbl - 2'd1;
                end else if (pl_shift == 32'd0) begin
                    res_a.kind       = KIND_EMPTY;
                    res_a.token_done = 1'b1;
                    v_a     = 1'b1;
                    go_idle = 1'b1;
                end else begin
                    n_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                if (packed_tok) begin
                    n_pl   = two_nibs ? pl_m2 : pl_m1;
                    n_stop = two_nibs ? (stop_after0 || (!hex_tok && i_byte[3:0] == NIB_STOP))
                                      : stop_after0;
                    if (nib0[8]) begin
                        res_a.kind       = KIND_CHAR;
                        res_a.value      = nib0[7:0];
                        res_a.token_done = pay_done && !nib1[8];
                        v_a = 1'b1;
                    end else if (pay_done && !nib1[8]) begin
                        // The closing byte produced nothing: mark the end anyway.
                        res_a.kind       = KIND_EMPTY;
                        res_a.token_done = 1'b1;
                        v_a = 1'b1;
                    end
                    if (nib1[8]) begin
                        res_b.kind       = KIND_CHAR;
                        res_b.value      = nib1[7:0];
                        res_b.token_done = pay_done;
                        v_b = 1'b1;
                    end
                    go_idle = pay_done;
                end else begin
                    n_pl             = pl_m1;
                    res_a.kind       = KIND_CHAR;
                    res_a.value      = i_byte;
                    res_a.token_done = (pl_m1 == 32'd0);
                    v_a     = 1'b1;
                    go_idle = (pl_m1 == 32'd0);
                end
            end
            default: begin
                n_tok  = TK_NONE;
                n_lbl  = '0;
                n_pl   = '0;
                n_stop = 1'b0;
                if (is_sec) begin
                    n_sec   = sec_diff[1:0];
                    n_phase = PH_SEC;
                end else if (i_byte == i_cfg.raw8) begin
                    n_tok   = TK_RAW8;
                    n_phase = PH_LEN;
                end else if (i_byte == i_cfg.raw20) begin
                    n_tok   = TK_RAW20;
                    n_lbl   = 2'd2;
                    n_phase = PH_LEN;
                end else if (i_byte == i_cfg.raw32) begin
                    n_tok   = TK_RAW32;
                    n_lbl   = 2'd3;
                    n_phase = PH_LEN;
                end else if (i_byte == i_cfg.digits) begin
                    n_tok   = TK_DIG;
                    n_phase = PH_LEN;
                end else if (i_byte == i_cfg.hex) begin
                    n_tok   = TK_HEX;
                    n_phase = PH_LEN;
                end else begin
                    res_a.kind       = KIND_PRIMARY;
                    res_a.value      = i_byte;
                    res_a.token_done = 1'b1;
                    v_a     = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
        endcase

        if (go_idle) begin
            n_phase = PH_IDLE;
        end

        // A token still open at the end of the buffer is cut off.
        v_t = i_end && (n_phase != PH_IDLE);
        res_t.kind       = KIND_TRUNC;
        res_t.token_done = 1'b1;
        if (v_t) begin
            go_idle = 1'b1;
            n_phase = PH_IDLE;
        end

        if (go_idle) begin
            n_tok  = TK_NONE;
            n_lbl  = '0;
            n_pl   = '0;
            n_stop = 1'b0;
        end
    end

    // Pack the valid results to the front and flag the final one.
    always_comb begin
        o_res[0] = v_a ? res_a : (v_b ? res_b : res_t);
        o_res[1] = (v_a && v_b) ? res_b : res_t;
        o_res[2] = res_t;
        o_count  = 2'({1'b0, v_a} + {1'b0, v_b} + {1'b0, v_t});
        o_res[0].last = (o_count == 2'd1);
        o_res[1].last = (o_count == 2'd2);
        o_res[2].last = (o_count == 2'd3);
    end

endmodule
`default_nettype wire

@@ src/dtsd_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_outq: result register
// Holds the results of one input byte and presents them one per transaction.
// ----------------------------------------------------------------------------
module dtsd_outq
    import dtsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_result i_res [RES_SLOTS],
    input  wire logic [1:0] i_count,
    input  wire logic  i_ready,
    output logic       o_valid,
    output t_result    o_res,
    output logic       o_can_load
);

    logic [1:0] r_cnt;
    t_result    r_slot [RES_SLOTS];
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule
`default_nettype wire

@@ src/dictionary_token_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The first result of a byte is shown in the cycle after its transaction.
// Throughput: one byte per cycle when it yields at most one result and m_axis_tready is
// high; a byte with more results holds the result register until its single read port drains it.
// Reset (synchronous, active low) returns the parser to idle, empties the result
// register and restores the default marker codes.
// ----------------------------------------------------------------------------
// dictionary_token_stream_decoder: compact token stream parser
// Decodes dictionary indices, raw strings and packed nibble strings byte by byte.
// ----------------------------------------------------------------------------
module dictionary_token_stream_decoder
    import dtsd_pkg::*;
#(
    parameter int SECONDARY_TABLE_COUNT = DEF_SEC_TABLE_COUNT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // buffer_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] value
    output logic [7:0]      m_axis_tuser,   // [2:0] kind, [4:3] table_res, [5] token_done
    output logic            m_axis_tlast,   // last
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg       cfg;
    t_result    core_res [RES_SLOTS];
    logic [1:0] core_count;
    t_result    out_res;
    logic       can_load;
    logic       accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    dtsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dtsd_core #(
        .SECONDARY_TABLE_COUNT (SECONDARY_TABLE_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .i_cfg    (cfg),
        .o_res    (core_res),
        .o_count  (core_count)
    );

    dtsd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (core_res),
        .i_count    (core_count),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_res      (out_res),
        .o_can_load (can_load)
    );

    assign m_axis_tdata = out_res.value;
    assign m_axis_tuser = {2'b00, out_res.token_done, out_res.table_res, out_res.kind};
    assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

@@ src/dtsd_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_chk: port checker
// Watches the decoder ports for result stream consistency.
// ----------------------------------------------------------------------------
module dtsd_chk
    import dtsd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [7:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // With nothing to deliver, the input side must be open.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] == KIND_TRUNC |-> m_axis_tuser[5] && m_axis_tlast)
        else $error("truncation result not closing");

    // An index token is always the only result of its byte.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == KIND_PRIMARY
            || m_axis_tuser[2:0] == KIND_SECONDARY) |-> m_axis_tuser[5] && m_axis_tlast)
        else $error("index result not final");

    a_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4:3] != 2'd0 |-> m_axis_tuser[2:0] == KIND_SECONDARY)
        else $error("table number on a non-secondary result");

endmodule

bind dictionary_token_stream_decoder dtsd_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ tb/sv/dictionary_token_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dictionary_token_stream_decoder_tb: self-checking testbench
// Streams directed and random token bytes into the decoder under several
// marker settings. A behavioral decoder predicts every result, and the
// monitor compares each output transaction with the oldest prediction.
// Both stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module dictionary_token_stream_decoder_tb;
    import dtsd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_item;

    // {buffer_end, data_byte}
    localparam logic [8:0] DIRECTED [30] = '{
        9'h000, 9'h0EC, 9'h0FF, 9'h1EF, 9'h0FD, 9'h0F0, 9'h000, 9'h002, 9'h041, 9'h0BE,
        9'h0FE, 9'h000, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h005, 9'h01A, 9'h0BC, 9'h0D0,
        9'h0FF, 9'h004, 9'h0F3, 9'h145, 9'h0FB, 9'h002, 9'h0AF, 9'h0FC, 9'h005, 9'h17E
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [7:0] m_axis_tuser;
    logic       m_axis_tlast;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = 3'd0;
    logic [7:0] i_cfg_data = 8'd0;

    // Behavioral copy of the decoder state and its marker registers.
    t_cfg        cfg;
    t_phase      parse_ph;
    t_tok        tok;
    logic [1:0]  len_left;
    logic [31:0] pay_left;
    logic [1:0]  sec_tab;
    logic        stop_seen;

    t_item   stream_bytes[$];
    t_result expected_results[$];
    t_item   next_item;
    t_result out_res;
    t_result want;
    logic    out_fire = 1'b0;
    logic    idle_on = 1'b1;
    int      send_gap = 0;
    int      sink_hold = 0;
    int      mismatch_count = 0;

    dictionary_token_stream_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic t_result mk_res(input logic [2:0] k, input logic [1:0] t,
                                       input logic [7:0] v, input logic d);
        return '{token_done: d, table_res: t, kind: k, value: v, last: 1'b0};
    endfunction

    function automatic void clear_token();
        parse_ph  = PH_IDLE;
        tok       = TK_NONE;
        len_left  = 2'd0;
        pay_left  = 32'd0;
        stop_seen = 1'b0;
    endfunction

    // Bit 8 set means a character is produced.
    function automatic logic [8:0] nibble_glyph(input logic [3:0] n);
        if (tok == TK_HEX)
            return {1'b1, (n < NIB_TEN) ? 8'(CH_ZERO + n) : 8'(CH_A + (n - NIB_TEN))};
        if (stop_seen) return 9'd0;
        if (n < NIB_TEN) return {1'b1, 8'(CH_ZERO + n)};
        if (n == NIB_DASH) return {1'b1, CH_DASH};
        if (n == NIB_DOT) return {1'b1, CH_DOT};
        if (n == NIB_STOP) begin
            stop_seen = 1'b1;
            return 9'd0;
        end
        return {1'b1, CH_QUEST};
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        t_result    step_res[$];
        t_result    tail;
        logic [8:0] c0;
        logic [8:0] c1;
        logic       done;
        int         diff;
        case (parse_ph)
            PH_SEC: begin
                step_res.push_back(mk_res(KIND_SECONDARY, sec_tab, b, 1'b1));
                clear_token();
            end
            PH_LEN: begin
                if (tok == TK_RAW20 && len_left == 2'd2)
                    pay_left = {pay_left[23:0], 4'h0, b[3:0]};
                else
                    pay_left = {pay_left[23:0], b};
                if (len_left != 2'd0) begin
                    len_left = len_left - 2'd1;
                end else if (pay_left == 32'd0) begin
                    step_res.push_back(mk_res(KIND_EMPTY, 2'd0, 8'd0, 1'b1));
                    clear_token();
                end else begin
                    parse_ph = PH_PAY;
                end
            end
            PH_PAY: begin
                if (tok == TK_DIG || tok == TK_HEX) begin
                    c1 = 9'd0;
                    c0 = nibble_glyph(b[7:4]);
                    pay_left = pay_left - 32'd1;
                    if (pay_left != 32'd0) begin
                        c1 = nibble_glyph(b[3:0]);
                        pay_left = pay_left - 32'd1;
                    end
                    done = (pay_left == 32'd0);
                    if (c0[8])
                        step_res.push_back(mk_res(KIND_CHAR, 2'd0, c0[7:0], done && !c1[8]));
                    if (c1[8])
                        step_res.push_back(mk_res(KIND_CHAR, 2'd0, c1[7:0], done));
                    if (done && !c0[8] && !c1[8])
                        step_res.push_back(mk_res(KIND_EMPTY, 2'd0, 8'd0, 1'b1));
                    if (done) clear_token();
                end else begin
                    pay_left = pay_left - 32'd1;
                    step_res.push_back(mk_res(KIND_CHAR, 2'd0, b, pay_left == 32'd0));
                    if (pay_left == 32'd0) clear_token();
                end
            end
            default: begin
                clear_token();
                diff = int'(b) - int'(cfg.sec_base);
                // The secondary prefix range wins over any marker that falls inside it.
                if (diff >= 0 && diff < DEF_SEC_TABLE_COUNT) begin
                    sec_tab  = 2'(diff);
                    parse_ph = PH_SEC;
                end else begin
                    if (b == cfg.raw8) begin
                        tok = TK_RAW8;
                    end else if (b == cfg.raw20) begin
                        tok = TK_RAW20;
                        len_left = 2'd2;
                    end else if (b == cfg.raw32) begin
                        tok = TK_RAW32;
                        len_left = 2'd3;
                    end else if (b == cfg.digits) begin
                        tok = TK_DIG;
                    end else if (b == cfg.hex) begin
                        tok = TK_HEX;
                    end else begin
                        step_res.push_back(mk_res(KIND_PRIMARY, 2'd0, b, 1'b1));
                    end
                    if (tok != TK_NONE) parse_ph = PH_LEN;
                end
            end
        endcase
        if (fin && parse_ph != PH_IDLE) begin
            step_res.push_back(mk_res(KIND_TRUNC, 2'd0, 8'd0, 1'b1));
            clear_token();
        end
        if (step_res.size() > 0) begin
            tail = step_res.pop_back();
            tail.last = 1'b1;
            step_res.push_back(tail);
        end
        foreach (step_res[i]) expected_results.push_back(step_res[i]);
    endtask

    // Byte driver: predicts each accepted transaction, then presents the next byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (stream_bytes.size() > 0) begin
                    next_item = stream_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.data;
                    s_axis_tlast  <= next_item.fin;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: samples at the rising edge, checks at the falling edge.
    always @(posedge i_clk) begin
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        out_res  = '{token_done: m_axis_tuser[5], table_res: m_axis_tuser[4:3],
                     kind: m_axis_tuser[2:0], value: m_axis_tdata, last: m_axis_tlast};
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_hold = 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (out_fire) sink_hold = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (out_fire) begin
            out_fire = 1'b0;
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: kind %0d table %0d value %h done %b last %b",
                             out_res.kind, out_res.table_res, out_res.value,
                             out_res.token_done, out_res.last);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (want !== out_res) begin
                    if (mismatch_count < 10)
                        $display({"mismatch (expected/actual): kind %0d/%0d table %0d/%0d ",
                                  "value %h/%h done %b/%b last %b/%b"},
                                 want.kind, out_res.kind, want.table_res, out_res.table_res,
                                 want.value, out_res.value, want.token_done,
                                 out_res.token_done, want.last, out_res.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SEC_BASE: cfg.sec_base = val;
            CFG_RAW8:     cfg.raw8     = val;
            CFG_RAW20:    cfg.raw20    = val;
            CFG_RAW32:    cfg.raw32    = val;
            CFG_DIGITS:   cfg.digits   = val;
            CFG_HEX:      cfg.hex      = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] base, input logic [7:0] r8, input logic [7:0] r20,
                             input logic [7:0] r32, input logic [7:0] dig, input logic [7:0] hx);
        write_reg(CFG_SEC_BASE, base);
        write_reg(CFG_RAW8, r8);
        write_reg(CFG_RAW20, r20);
        write_reg(CFG_RAW32, r32);
        write_reg(CFG_DIGITS, dig);
        write_reg(CFG_HEX, hx);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (stream_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly well-formed tokens built from the current markers, some cut short
    // by a buffer end, some plain noise bytes.
    task automatic run_random(input int n_items);
        logic [7:0] tok_bytes[$];
        t_item      it;
        int         pick;
        int         cnt;
        int         npay;
        int         cut;
        logic       fin_last;
        @(negedge i_clk);
        while (n_items > 0) begin
            tok_bytes.delete();
            pick = $urandom_range(0, 9);
            cnt  = $urandom_range(0, 5);
            npay = 0;
            case (pick)
                0, 1: tok_bytes.push_back(8'($urandom_range(0, 255)));
                2: begin
                    tok_bytes.push_back(8'(cfg.sec_base + $urandom_range(0, 3)));
                    tok_bytes.push_back(8'($urandom_range(0, 255)));
                end
                3: begin
                    tok_bytes.push_back(cfg.raw8);
                    tok_bytes.push_back(8'(cnt));
                    npay = cnt;
                end
                4: begin
                    tok_bytes.push_back(cfg.raw20);
                    tok_bytes.push_back({4'($urandom_range(0, 15)), 4'h0});
                    tok_bytes.push_back(8'd0);
                    tok_bytes.push_back(8'(cnt));
                    npay = cnt;
                end
                5: begin
                    tok_bytes.push_back(cfg.raw32);
                    repeat (3) tok_bytes.push_back(8'd0);
                    tok_bytes.push_back(8'(cnt));
                    npay = cnt;
                end
                default: begin
                    cnt = $urandom_range(0, 9);
                    tok_bytes.push_back((pick < 8) ? cfg.digits : cfg.hex);
                    tok_bytes.push_back(8'(cnt));
                    npay = (cnt + 1) / 2;
                end
            endcase
            repeat (npay) tok_bytes.push_back(8'($urandom_range(0, 255)));
            cut = tok_bytes.size() - 1;
            fin_last = ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(0, tok_bytes.size() - 1);
                fin_last = 1'b1;
            end
            for (int i = 0; i <= cut; i++)
                stream_bytes.push_back('{data: tok_bytes[i], fin: fin_last && (i == cut)});
            n_items -= cut + 1;
        end
        // Close any open token so the next register writes find the parser idle.
        it = stream_bytes.pop_back();
        it.fin = 1'b1;
        stream_bytes.push_back(it);
    endtask

    initial begin
        cfg = '{sec_base: RST_SEC_BASE, raw8: RST_RAW8, raw20: RST_RAW20,
                raw32: RST_RAW32, digits: RST_DIGITS, hex: RST_HEX};
        clear_token();
        sec_tab = 2'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (DIRECTED[i])
            stream_bytes.push_back('{data: DIRECTED[i][7:0], fin: DIRECTED[i][8]});
        wait_drained();

        // Lowest base; colliding markers resolve by priority.
        write_all(8'd0, 8'd255, 8'd255, 8'd0, 8'd128, 8'd4);
        run_random(40);
        wait_drained();

        // Highest base, low markers, hex marker shadowed by the prefix range.
        idle_on = 1'b0;
        write_all(8'd252, 8'd0, 8'd1, 8'd2, 8'd3, 8'd255);
        run_random(40);
        wait_drained();
        idle_on = 1'b1;

        write_all(8'($urandom_range(0, 252)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(40);
        wait_drained();

        write_all(RST_SEC_BASE, RST_RAW8, RST_RAW20, RST_RAW32, RST_DIGITS, RST_HEX);
        run_random(50);
        wait_drained();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
